/* hdl/smao_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smao_pkg
// shared types and constants of the stack machine execution unit
// ----------------------------------------------------------------------------
package smao_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int DEPTH_W     = 7;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // command codes of the input item
   typedef enum logic [2:0] {
      CMD_PUSH = 3'd0,
      CMD_SWAP = 3'd1,
      CMD_ADD  = 3'd2,
      CMD_SUB  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_NOP  = 3'd5
   } cmd_type;

   // status codes of the result item
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // per-cell load select
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_ABOVE = 2'd1,
      CELL_BELOW = 2'd2
   } cell_op_type;

endpackage : smao_pkg
`default_nettype wire

/* hdl/smao_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smao_cell
// one stack entry; loads from its upper or lower neighbor or holds
// ----------------------------------------------------------------------------
module smao_cell (
   input  wire logic                          clock,
   input  wire smao_pkg::cell_op_type         op,
   input  wire logic [smao_pkg::DATA_W-1:0]   above_data,
   input  wire logic [smao_pkg::DATA_W-1:0]   below_data,
   output logic      [smao_pkg::DATA_W-1:0]   value
);
   import smao_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      unique case (op)
         CELL_ABOVE: value_in = above_data;
         CELL_BELOW: value_in = below_data;
         default:    value_in = value_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule : smao_cell
`default_nettype wire

/* hdl/smao_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smao_div
// radix-2 restoring signed divider, truncates toward zero
// ----------------------------------------------------------------------------
module smao_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [smao_pkg::DATA_W-1:0]   dividend,
   input  wire logic [smao_pkg::DATA_W-1:0]   divisor,
   output logic                               done,
   output logic      [smao_pkg::DATA_W-1:0]   quotient
);
   import smao_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // load magnitudes, remember sign of the quotient
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
         den_in  = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;

endmodule : smao_div
`default_nettype wire

/* hdl/stack_machine_alu_ops.sv */
`default_nettype none
// results: push, swap, add, sub, nop and every error case register their result at the
//   transfer; div registers it when the 32-step radix-2 divider finishes
// throughput: one item per cycle while the result side is ready; no command is taken during a div
// reset: synchronous active high; empties the stack, drops any pending result;
//   entry contents are not cleared and are never read before a push writes them
// ----------------------------------------------------------------------------
// stack_machine_alu_ops
// execution unit of a stack bytecode machine built as a row of shifting cells
// ----------------------------------------------------------------------------
module stack_machine_alu_ops (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // cmd[2:0], push_value[34:3], zero[39:35]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata   // status[1:0], top_value[33:2], depth[40:34], zero
);
   import smao_pkg::*;

   // top-level controller states
   typedef enum logic {
      ST_IDLE,
      ST_DIV
   } state_type;

   // whole-stack move for one command
   typedef enum logic [1:0] {
      STK_HOLD,
      STK_PUSH,
      STK_POP,
      STK_SWAP
   } stack_op_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, status_in;
   logic [DATA_W-1:0]  rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0] rsp_depth_ff;

   // request fields
   logic               req_xfer;
   cmd_type            req_cmd;
   logic [DATA_W-1:0]  req_push_value;

   // stack row
   logic [DATA_W-1:0]  cell_q [STACK_DEPTH];
   stack_op_type       stack_op;
   logic [DATA_W-1:0]  new_data;   // enters the top cell on push or pop
   logic [DATA_W-1:0]  new_top;

   logic               is_full;
   logic               is_short;
   logic [DATA_W-1:0]  opnd_a;     // second entry, left operand
   logic [DATA_W-1:0]  opnd_b;     // top entry, right operand
   logic               load_rsp;

   // divider
   logic               div_start;
   logic               div_done;
   logic [DATA_W-1:0]  div_quo;

   assign req_cmd        = cmd_type'(req_tdata[2:0]);
   assign req_push_value = req_tdata[34:3];

   // a new command is taken once the controller is idle and the result register is free or drains this cycle
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   assign opnd_b   = cell_q[0];
   assign opnd_a   = cell_q[1];
   assign is_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_short = (count_ff < CNT_W'(2));

   // command decode and result formation
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      stack_op  = STK_HOLD;
      new_data  = req_push_value;
      new_top   = cell_q[0];
      status_in = ST_OK;
      load_rsp  = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               load_rsp = 1'b1;
               unique case (req_cmd)
                  CMD_PUSH: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        stack_op = STK_PUSH;
                        new_data = req_push_value;
                        new_top  = req_push_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_SWAP: begin
                     if (is_short) begin
                        status_in = ST_SHORT;
                     end else begin
                        stack_op = STK_SWAP;
                        new_top  = opnd_a;
                     end
                  end
                  CMD_ADD, CMD_SUB: begin
                     if (is_short) begin
                        status_in = ST_SHORT;
                     end else begin
                        stack_op = STK_POP;
                        new_data = (req_cmd == CMD_ADD) ? (opnd_a + opnd_b)
                                                        : (opnd_a - opnd_b);
                        new_top  = new_data;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_DIV: begin
                     if (is_short) begin
                        status_in = ST_SHORT;
                     end else if (opnd_b == '0) begin
                        status_in = ST_DIVZERO;
                     end else begin
                        // result comes later from the divider
                        load_rsp  = 1'b0;
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: begin
                     // nop and unused codes leave the stack alone
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               stack_op = STK_POP;
               new_data = div_quo;
               new_top  = div_quo;
               count_in = count_ff - CNT_W'(1);
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_top_in   = (count_in != '0) ? new_top : '0;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);

   // per-cell move select and the row of cells
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] above;
      logic [DATA_W-1:0] below;
      cell_op_type       op_sel;

      if (i == 0) begin : g_top
         assign above = new_data;
      end else begin : g_inner
         assign above = cell_q[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = '0;
      end else begin : g_mid
         assign below = cell_q[i+1];
      end

      always_comb begin
         unique case (stack_op)
            STK_PUSH: op_sel = CELL_ABOVE;
            STK_POP:  op_sel = (i == 0) ? CELL_ABOVE : CELL_BELOW;
            STK_SWAP: op_sel = (i == 0) ? CELL_BELOW
                             : ((i == 1) ? CELL_ABOVE : CELL_HOLD);
            default:  op_sel = CELL_HOLD;
         endcase
      end

      smao_cell u_cell (
         .clock      (clock),
         .op         (op_sel),
         .above_data (above),
         .below_data (below),
         .value      (cell_q[i])
      );
   end

   smao_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (opnd_a),
      .divisor  (opnd_b),
      .done     (div_done),
      .quotient (div_quo)
   );

   // controller state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_in;
         rsp_top_ff    <= rsp_top_in;
         rsp_depth_ff  <= DEPTH_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_depth_ff, rsp_top_ff, rsp_status_ff};

   // checks

   // the divider only finishes while the controller waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside div wait");

   // entry count never passes the stack size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond capacity");

   // a push to a stack with room grows it by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_cmd == CMD_PUSH && !is_full)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the stack");

   // a result waiting is never overwritten by a new load
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !load_rsp)
      else $error("pending result overwritten");

endmodule : stack_machine_alu_ops
`default_nettype wire

/* verif/stack_machine_alu_ops_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_alu_ops_checker
// watches both streams of the stack execution unit, keeps its own copy of
// the operand stack to predict every result and compares in arrival order
// ----------------------------------------------------------------------------
module stack_machine_alu_ops_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,   // cmd[2:0], push_value[34:3], zero[39:35]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,   // status[1:0], top_value[33:2], depth[40:34], zero
   output int               fail_count,
   output int               outstanding
);
   import smao_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   top_value;
      logic [DEPTH_W-1:0]  depth;
   } stack_result_type;

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   int unsigned       stack_len;
   stack_result_type  result_q [$];

   initial outstanding = 0;

   // signed quotient rounded toward zero, most negative / -1 wraps
   function automatic logic [DATA_W-1:0] quotient_trunc(logic [DATA_W-1:0] num,
                                                        logic [DATA_W-1:0] den);
      logic [DATA_W-1:0] num_mag;
      logic [DATA_W-1:0] den_mag;
      logic [DATA_W-1:0] mag;
      num_mag = num[DATA_W-1] ? -num : num;
      den_mag = den[DATA_W-1] ? -den : den;
      mag     = num_mag / den_mag;
      return (num[DATA_W-1] != den[DATA_W-1]) ? -mag : mag;
   endfunction

   // applies one command to the local stack and returns what the block must report
   function automatic stack_result_type execute_cmd(logic [2:0] op,
                                                    logic [DATA_W-1:0] operand);
      stack_result_type  res;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      res.status = ST_OK;
      case (op)
         CMD_PUSH: begin
            if (stack_len >= STACK_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               stack_mem[stack_len] = operand;
               stack_len++;
            end
         end
         CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV: begin
            if (stack_len < 2) begin
               res.status = ST_SHORT;
            end else begin
               lhs = stack_mem[stack_len - 2];
               rhs = stack_mem[stack_len - 1];
               if (op == CMD_SWAP) begin
                  stack_mem[stack_len - 2] = rhs;
                  stack_mem[stack_len - 1] = lhs;
               end else if (op == CMD_DIV && rhs == '0) begin
                  res.status = ST_DIVZERO;
               end else begin
                  case (op)
                     CMD_ADD: lhs = lhs + rhs;
                     CMD_SUB: lhs = lhs - rhs;
                     default: lhs = quotient_trunc(lhs, rhs);
                  endcase
                  stack_mem[stack_len - 2] = lhs;
                  stack_len--;
               end
            end
         end
         default: ;   // nop and the unused codes
      endcase
      res.top_value = (stack_len != 0) ? stack_mem[stack_len - 1] : '0;
      res.depth     = DEPTH_W'(stack_len);
      return res;
   endfunction

   always @(posedge clock) begin
      stack_result_type want;
      logic [1:0]       got_status;
      logic [31:0]      got_top;
      logic [6:0]       got_depth;
      if (reset) begin
         stack_len = 0;
         result_q.delete();
      end else begin
         // results first, so a stray one is never matched to an item of this edge
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[1:0];
            got_top    = rsp_tdata[33:2];
            got_depth  = rsp_tdata[40:34];
            if (result_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with none pending: status %0d top %h depth %0d",
                           $realtime, got_status, got_top, got_depth);
            end else begin
               want = result_q.pop_front();
               if (got_status != want.status || got_top != want.top_value ||
                   got_depth != want.depth) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected status %0d top %h depth %0d,",
                               " got status %0d top %h depth %0d"},
                              $realtime, want.status, want.top_value, want.depth,
                              got_status, got_top, got_depth);
               end
            end
         end
         if (req_tvalid && req_tready)
            result_q.push_back(execute_cmd(req_tdata[2:0], req_tdata[34:3]));
      end
      outstanding = result_q.size();
   end

endmodule : stack_machine_alu_ops_checker

/* verif/stack_machine_alu_ops_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_alu_ops_test
// drives commands into the stack execution unit with bursty traffic and a
// throttled result side; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module stack_machine_alu_ops_test;
   import smao_pkg::*;

   localparam int          TOTAL_ITEMS    = 450;
   localparam int          HOLD_OFF_LEN   = 400;   // long result-side stall
   localparam int          HOLD_OFF_AFTER = 60;    // transfers before the stall starts
   localparam int          WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
   localparam int          DRAIN_CYCLES   = 40;    // extra wait for stray results after the last pending one
   localparam logic [31:0] VAL_MIN        = 32'h8000_0000;
   localparam logic [31:0] VAL_MAX        = 32'h7fff_ffff;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;    // cmd[2:0], push_value[34:3], zero[39:35]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // status[1:0], top_value[33:2], depth[40:34], zero

   int fail_count;
   int outstanding;
   int items_sent  = 0;
   int burst_left  = 0;
   int quiet_count = 0;

   // receiver pattern state
   int hold_off_left = 0;
   bit hold_off_done = 1'b0;
   int mode          = 0;
   int mode_left     = 0;

   stack_machine_alu_ops u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stack_machine_alu_ops_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // push operands: zeros for divide by zero, small values for exact
   // quotients, the extremes for wrap, and plain random words
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'($urandom_range(0, 6)) - 32'd3;
         2: begin
            case ($urandom_range(0, 3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return '1;
               default: return 32'd1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // one transfer on the command side; entered and left at a falling edge.
   // the sender runs in bursts and may idle between them
   task automatic send_item(input logic [2:0] op, input logic [31:0] operand);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         // long bursts now and then give stretches with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, operand, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // result side: modes of steady, mostly-ready and mostly-stalled, plus one
   // long hold-off while the sender keeps offering so the input backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else if (!hold_off_done && items_sent >= HOLD_OFF_AFTER) begin
         hold_off_done = 1'b1;
         hold_off_left = HOLD_OFF_LEN - 1;
         rsp_tready    <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 60);
         end
         mode_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog: any transfer on either side resets the quiet count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_count <= 0;
      end else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [2:0] op;
      int         segment;
      int         pick;
      segment = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: operators on a short stack, wrap on add, sub and div,
      // divide by zero, truncation of a negative quotient, nop and the
      // unused command codes
      send_item(CMD_SWAP, '0);
      send_item(CMD_ADD,  '1);
      send_item(CMD_DIV,  '0);
      send_item(CMD_PUSH, VAL_MAX);
      send_item(CMD_SUB,  VAL_MIN);
      send_item(CMD_PUSH, 32'd1);
      send_item(CMD_ADD,  '0);          // max + 1 wraps to min
      send_item(CMD_PUSH, '0);
      send_item(CMD_DIV,  '0);          // zero divisor, stack kept
      send_item(CMD_SWAP, '1);
      send_item(CMD_NOP,  '1);
      send_item(3'd6,     VAL_MAX);     // unused codes behave as nop
      send_item(3'd7,     VAL_MIN);
      send_item(CMD_PUSH, '1);
      send_item(CMD_DIV,  '0);          // min / -1 wraps to min
      send_item(CMD_PUSH, 32'd1);
      send_item(CMD_SUB,  '0);          // min - 1 wraps to max
      send_item(CMD_PUSH, -32'sd7);
      send_item(CMD_PUSH, 32'd2);
      send_item(CMD_DIV,  '0);          // -7 / 2 truncates to -3
      send_item(CMD_SUB,  '0);          // max - (-3) wraps
      send_item(CMD_PUSH, VAL_MIN);
      send_item(CMD_DIV,  '0);
      send_item(CMD_ADD,  '0);

      // random: fill to overflow, mixed traffic, then drain to too short
      while (items_sent < TOTAL_ITEMS) begin
         case (segment % 3)
            0: begin
               repeat (STACK_DEPTH + 2) send_item(CMD_PUSH, pick_value());
            end
            1: begin
               repeat (100) begin
                  if ($urandom_range(0, 2) == 0)
                     send_item(CMD_PUSH, pick_value());
                  else
                     send_item(3'($urandom_range(1, 7)), $urandom());
               end
            end
            default: begin
               repeat (STACK_DEPTH + 8) begin
                  pick = $urandom_range(0, 15);
                  if (pick == 0)
                     op = CMD_SWAP;
                  else if (pick < 6)
                     op = CMD_ADD;
                  else if (pick < 11)
                     op = CMD_SUB;
                  else
                     op = CMD_DIV;
                  send_item(op, $urandom());
               end
            end
         endcase
         segment++;
      end
      req_tvalid <= 1'b0;

      // wait out every pending result, then a little longer for stray ones
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule : stack_machine_alu_ops_test
